// ----- src/allele_identity_pair_counter_top_assert.svh -----
// Assertion macros for the pair counter, clocked on aclk and held off in reset.
`ifndef ALLELE_IDENTITY_PAIR_COUNTER_TOP_ASSERT_SVH
`define ALLELE_IDENTITY_PAIR_COUNTER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AIPC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pair counter assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define AIPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pair counter assertion failed");

`endif

// ----- src/aipc_pkg.sv -----
`default_nettype none

package aipc_pkg;

    localparam int DEF_MAX_INDIVIDUALS = 1024;
    localparam int DEF_COUNT_BITS      = 48;
    localparam int ALLELE_BITS         = 16;
    localparam int POP_BITS            = 6;

    typedef struct packed {
        logic [ALLELE_BITS-1:0] allele_first;
        logic [ALLELE_BITS-1:0] allele_second;
        logic [POP_BITS-1:0]    pop_index;
    } genotype_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic indiv_en;
        logic pair_en;
        logic clear;
    } acc_ctrl_t;

endpackage

`default_nettype wire

// ----- src/aipc_store.sv -----
`default_nettype none

module aipc_store #(
    parameter int DEPTH = aipc_pkg::DEF_MAX_INDIVIDUALS
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  aipc_pkg::genotype_t      wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output aipc_pkg::genotype_t      rd_data
);
    import aipc_pkg::*;

    genotype_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- src/aipc_counters.sv -----
`default_nettype none

module aipc_counters #(
    parameter int COUNT_BITS = aipc_pkg::DEF_COUNT_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  aipc_pkg::acc_ctrl_t   ctrl,
    input  aipc_pkg::genotype_t   new_geno,
    input  aipc_pkg::genotype_t   cur_geno,
    input  aipc_pkg::genotype_t   stored_geno,
    output logic [COUNT_BITS-1:0] wi_match,
    output logic [COUNT_BITS-1:0] wi_total,
    output logic [COUNT_BITS-1:0] wp_match,
    output logic [COUNT_BITS-1:0] wp_total,
    output logic [COUNT_BITS-1:0] bp_match,
    output logic [COUNT_BITS-1:0] bp_total
);
    import aipc_pkg::*;

    function automatic logic [1:0] pairing(input logic [ALLELE_BITS-1:0] x,
                                           input logic [ALLELE_BITS-1:0] y);
        logic present;
        present = (x != '0) && (y != '0);
        return {present && (x == y), present};
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] c,
                                                      input logic [2:0] v);
        logic [COUNT_BITS:0] s;
        s = {1'b0, c} + (COUNT_BITS+1)'(v);
        return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
    endfunction

    logic [1:0] p0, p1, p2, p3;
    logic [2:0] pair_match, pair_total;
    logic       pop_same;
    logic       indiv_present;
    logic       indiv_equal;

    always_comb begin
        p0 = pairing(stored_geno.allele_first,  cur_geno.allele_first);
        p1 = pairing(stored_geno.allele_first,  cur_geno.allele_second);
        p2 = pairing(stored_geno.allele_second, cur_geno.allele_first);
        p3 = pairing(stored_geno.allele_second, cur_geno.allele_second);
        pair_match = 3'(p0[1]) + 3'(p1[1]) + 3'(p2[1]) + 3'(p3[1]);
        pair_total = 3'(p0[0]) + 3'(p1[0]) + 3'(p2[0]) + 3'(p3[0]);
        pop_same = (stored_geno.pop_index == cur_geno.pop_index);
        indiv_present = (new_geno.allele_first != '0) && (new_geno.allele_second != '0);
        indiv_equal = indiv_present && (new_geno.allele_first == new_geno.allele_second);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            wi_match <= '0;
            wi_total <= '0;
            wp_match <= '0;
            wp_total <= '0;
            bp_match <= '0;
            bp_total <= '0;
        end else if (ctrl.indiv_en) begin
            wi_match <= sat_add(wi_match, 3'(indiv_equal));
            wi_total <= sat_add(wi_total, 3'(indiv_present));
        end else if (ctrl.pair_en) begin
            if (pop_same) begin
                wp_match <= sat_add(wp_match, pair_match);
                wp_total <= sat_add(wp_total, pair_total);
            end else begin
                bp_match <= sat_add(bp_match, pair_match);
                bp_total <= sat_add(bp_total, pair_total);
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/allele_identity_pair_counter_top.sv -----
// Channel   Ports                          Moves
// s_        s_valid, s_ready, fields       one genotype request
// m_        m_valid, m_ready, six counts   counts at the end of the data
//
// A request is taken only in idle and occupies the block while it scans the N genotypes
// stored for the locus (an empty store skips the scan); the single compare and
// count unit takes one stored genotype per cycle from the store's read port.
// Reset clears the counters and the fill count; the store itself is never cleared.
// A waiting result does not stop intake; only a second data end waits for m_ready.
`default_nettype none

module allele_identity_pair_counter_top #(
    parameter int MAX_INDIVIDUALS = aipc_pkg::DEF_MAX_INDIVIDUALS,
    parameter int COUNT_BITS      = aipc_pkg::DEF_COUNT_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [aipc_pkg::ALLELE_BITS-1:0]  s_allele_first,
    input  logic [aipc_pkg::ALLELE_BITS-1:0]  s_allele_second,
    input  logic [aipc_pkg::POP_BITS-1:0]     s_pop_index,
    input  logic                              s_last_in_locus,
    input  logic                              s_data_end,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [COUNT_BITS-1:0]             m_within_indiv_match,
    output logic [COUNT_BITS-1:0]             m_within_indiv_total,
    output logic [COUNT_BITS-1:0]             m_within_pop_match,
    output logic [COUNT_BITS-1:0]             m_within_pop_total,
    output logic [COUNT_BITS-1:0]             m_between_pop_match,
    output logic [COUNT_BITS-1:0]             m_between_pop_total
);
    import aipc_pkg::*;

    localparam int ADDR_BITS = $clog2(MAX_INDIVIDUALS);
    localparam int CNT_BITS  = $clog2(MAX_INDIVIDUALS + 1);
    localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(MAX_INDIVIDUALS);

    state_t              state_reg, state_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic [CNT_BITS-1:0] scan_len_reg, scan_len_next;
    logic [CNT_BITS-1:0] idx_reg, idx_next;
    logic [CNT_BITS-1:0] idx_inc;
    logic                rd_valid_reg;
    logic                data_end_reg;
    genotype_t           cur_reg;
    genotype_t           new_geno;
    genotype_t           stored_geno;
    acc_ctrl_t           acc_ctrl;
    logic                accept;
    logic                store_full;
    logic                rd_en;
    logic                snapshot;

    logic [COUNT_BITS-1:0] wi_match, wi_total, wp_match, wp_total, bp_match, bp_total;

    assign new_geno   = '{allele_first: s_allele_first, allele_second: s_allele_second,
                          pop_index: s_pop_index};
    assign accept     = s_valid && s_ready;
    assign store_full = (count_reg == FULL_COUNT);
    assign idx_inc    = idx_reg + CNT_BITS'(1);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (count_reg == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (idx_inc == scan_len_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!data_end_reg || !m_valid || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        rd_en     = (state_reg == ST_SCAN);
        snapshot  = (state_reg == ST_FINISH) && data_end_reg && (!m_valid || m_ready);
        acc_ctrl  = '{indiv_en: accept, pair_en: rd_valid_reg, clear: snapshot};
        idx_next  = rd_en ? idx_inc : '0;
        count_next    = count_reg;
        scan_len_next = scan_len_reg;
        if (accept) begin
            scan_len_next = count_reg;
            if (s_last_in_locus || s_data_end) begin
                count_next = '0;
            end else if (!store_full) begin
                count_next = count_reg + CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
            m_valid      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            rd_valid_reg <= rd_en;
            if (snapshot) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        scan_len_reg <= scan_len_next;
        if (accept) begin
            cur_reg      <= new_geno;
            data_end_reg <= s_data_end;
        end
        if (snapshot) begin
            m_within_indiv_match <= wi_match;
            m_within_indiv_total <= wi_total;
            m_within_pop_match   <= wp_match;
            m_within_pop_total   <= wp_total;
            m_between_pop_match  <= bp_match;
            m_between_pop_total  <= bp_total;
        end
    end

    aipc_store #(
        .DEPTH (MAX_INDIVIDUALS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (accept && !store_full),
        .wr_addr (count_reg[ADDR_BITS-1:0]),
        .wr_data (new_geno),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[ADDR_BITS-1:0]),
        .rd_data (stored_geno)
    );

    aipc_counters #(
        .COUNT_BITS (COUNT_BITS)
    ) u_counters (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (acc_ctrl),
        .new_geno    (new_geno),
        .cur_geno    (cur_reg),
        .stored_geno (stored_geno),
        .wi_match    (wi_match),
        .wi_total    (wi_total),
        .wp_match    (wp_match),
        .wp_total    (wp_total),
        .bp_match    (bp_match),
        .bp_total    (bp_total)
    );

`include "allele_identity_pair_counter_top_assert.svh"

    `AIPC_ASSERT_NOW(a_scan_in_range, state_reg == ST_SCAN, idx_reg < scan_len_reg)
    `AIPC_ASSERT_NOW(a_count_bounded, 1'b1, count_reg <= FULL_COUNT)
    `AIPC_ASSERT_NOW(a_read_in_scan, rd_valid_reg,
                     state_reg == ST_SCAN || state_reg == ST_DRAIN)
    `AIPC_ASSERT_NEXT(a_result_from_finish, !m_valid,
                      !m_valid || $past(state_reg) == ST_FINISH)

endmodule

`default_nettype wire

// ----- test/tb_allele_identity_pair_counter_top.sv -----
`timescale 1ns / 1ps

module tb_allele_identity_pair_counter_top;

    import aipc_pkg::*;

    localparam int COUNT_W      = DEF_COUNT_BITS;
    localparam int STORE_DEPTH  = DEF_MAX_INDIVIDUALS;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int SETTLE       = 1100;
    localparam int RANDOM_ITEMS = 485;
    localparam int MIN_SETS     = 30;
    localparam int CALM_AFTER   = 420;

    localparam int WI_MATCH = 0;
    localparam int WI_TOTAL = 1;
    localparam int WP_MATCH = 2;
    localparam int WP_TOTAL = 3;
    localparam int BP_MATCH = 4;
    localparam int BP_TOTAL = 5;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [5:0][COUNT_W-1:0] tally_set_t;

    typedef struct {
        genotype_t geno;
        logic      last_in_locus;
        logic      data_end;
        bit        drain_first;
        bit        calm;
    } request_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [ALLELE_BITS-1:0] s_allele_first = '0;
    logic [ALLELE_BITS-1:0] s_allele_second = '0;
    logic [POP_BITS-1:0] s_pop_index = '0;
    logic s_last_in_locus = 1'b0;
    logic s_data_end = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [COUNT_W-1:0] m_within_indiv_match;
    logic [COUNT_W-1:0] m_within_indiv_total;
    logic [COUNT_W-1:0] m_within_pop_match;
    logic [COUNT_W-1:0] m_within_pop_total;
    logic [COUNT_W-1:0] m_between_pop_match;
    logic [COUNT_W-1:0] m_between_pop_total;

    request_t pending_q[$];
    tally_set_t expected_q[$];

    genotype_t geno_store [STORE_DEPTH];
    int unsigned stored_n = 0;
    tally_set_t running = '0;

    logic s_took = 1'b0;
    logic calm = 1'b0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned cycle_count = 0;
    int unsigned requests_total = 0;
    int unsigned requests_taken = 0;
    int unsigned sets_queued = 0;
    int unsigned results_seen = 0;
    int unsigned errors = 0;

    allele_identity_pair_counter_top DUT (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_allele_first       (s_allele_first),
        .s_allele_second      (s_allele_second),
        .s_pop_index          (s_pop_index),
        .s_last_in_locus      (s_last_in_locus),
        .s_data_end           (s_data_end),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_within_indiv_match (m_within_indiv_match),
        .m_within_indiv_total (m_within_indiv_total),
        .m_within_pop_match   (m_within_pop_match),
        .m_within_pop_total   (m_within_pop_total),
        .m_between_pop_match  (m_between_pop_match),
        .m_between_pop_total  (m_between_pop_total)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic count_t sat_add(count_t c, int unsigned v);
        logic [COUNT_W:0] sum;
        sum = {1'b0, c} + (COUNT_W+1)'(v);
        return sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
    endfunction

    function automatic string tally_name(int k);
        case (k)
            WI_MATCH: return "within_indiv_match";
            WI_TOTAL: return "within_indiv_total";
            WP_MATCH: return "within_pop_match";
            WP_TOTAL: return "within_pop_total";
            BP_MATCH: return "between_pop_match";
            default:  return "between_pop_total";
        endcase
    endfunction

    function automatic logic [ALLELE_BITS-1:0] pick_allele();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll < 5) begin
            return '0;
        end else if (roll < 15) begin
            return ALLELE_BITS'($urandom_range(1, 4));
        end else if (roll < 17) begin
            return '1;
        end else begin
            return ALLELE_BITS'($urandom_range(1, 65535));
        end
    endfunction

    function automatic logic [POP_BITS-1:0] pick_pop();
        if ($urandom_range(0, 9) < 7) begin
            return POP_BITS'($urandom_range(0, 3));
        end else begin
            return POP_BITS'($urandom_range(0, 63));
        end
    endfunction

    task automatic push_request(input logic [ALLELE_BITS-1:0] a1, input logic [ALLELE_BITS-1:0] a2,
                                input logic [POP_BITS-1:0] pop, input logic le, input logic de,
                                input bit drain, input bit quiet);
        request_t r;
        r.geno.allele_first = a1;
        r.geno.allele_second = a2;
        r.geno.pop_index = pop;
        r.last_in_locus = le;
        r.data_end = de;
        r.drain_first = drain;
        r.calm = quiet;
        pending_q.push_back(r);
        requests_total++;
        if (de) begin
            sets_queued++;
        end
    endtask

    // Updates the running identity counts for one accepted genotype request.
    task automatic tally_request(input request_t r);
        int unsigned i;
        int unsigned k;
        int unsigned m;
        int unsigned t;
        logic [ALLELE_BITS-1:0] x;
        logic [ALLELE_BITS-1:0] y;
        if (r.geno.allele_first != 0 && r.geno.allele_second != 0) begin
            running[WI_TOTAL] = sat_add(running[WI_TOTAL], 1);
            if (r.geno.allele_first == r.geno.allele_second) begin
                running[WI_MATCH] = sat_add(running[WI_MATCH], 1);
            end
        end
        for (i = 0; i < stored_n; i++) begin
            m = 0;
            t = 0;
            for (k = 0; k < 4; k++) begin
                x = k[1] ? geno_store[i].allele_second : geno_store[i].allele_first;
                y = k[0] ? r.geno.allele_second : r.geno.allele_first;
                if (x != 0 && y != 0) begin
                    t++;
                    if (x == y) begin
                        m++;
                    end
                end
            end
            if (geno_store[i].pop_index == r.geno.pop_index) begin
                running[WP_MATCH] = sat_add(running[WP_MATCH], m);
                running[WP_TOTAL] = sat_add(running[WP_TOTAL], t);
            end else begin
                running[BP_MATCH] = sat_add(running[BP_MATCH], m);
                running[BP_TOTAL] = sat_add(running[BP_TOTAL], t);
            end
        end
        if (stored_n < STORE_DEPTH) begin
            geno_store[stored_n] = r.geno;
            stored_n++;
        end
        if (r.last_in_locus || r.data_end) begin
            stored_n = 0;
        end
        if (r.data_end) begin
            expected_q.push_back(running);
            running = '0;
        end
    endtask

    always @(negedge aclk) begin : drive_requests
        request_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_took) begin
            if (gap_left != 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_q.size() == 0 ||
                         (pending_q[0].drain_first && expected_q.size() != 0)) begin
                s_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(0, 17);
                s_valid <= 1'b0;
            end else begin
                nxt = pending_q.pop_front();
                s_allele_first <= nxt.geno.allele_first;
                s_allele_second <= nxt.geno.allele_second;
                s_pop_index <= nxt.geno.pop_index;
                s_last_in_locus <= nxt.last_in_locus;
                s_data_end <= nxt.data_end;
                s_valid <= 1'b1;
                if (nxt.calm) begin
                    calm <= 1'b1;
                end
            end
        end
    end

    always @(negedge aclk) begin : drive_result_ready
        if (!aresetn || calm) begin
            m_ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 17);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : watch_channels
        request_t r;
        tally_set_t want;
        tally_set_t got;
        int k;
        cycle_count++;
        if (!aresetn) begin
            s_took <= 1'b0;
        end else begin
            s_took <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                r.geno.allele_first = s_allele_first;
                r.geno.allele_second = s_allele_second;
                r.geno.pop_index = s_pop_index;
                r.last_in_locus = s_last_in_locus;
                r.data_end = s_data_end;
                r.drain_first = 1'b0;
                r.calm = 1'b0;
                tally_request(r);
                requests_taken++;
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    $error("count result with no data end request pending");
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    got = {m_between_pop_total, m_between_pop_match, m_within_pop_total,
                           m_within_pop_match, m_within_indiv_total, m_within_indiv_match};
                    for (k = 0; k < 6; k++) begin
                        if (got[k] !== want[k]) begin
                            $error("%s: expected %0d, actual %0d", tally_name(k),
                                   want[k], got[k]);
                            errors++;
                        end
                    end
                end
            end
        end
    end

    initial begin : run_test
        int unsigned len;
        int unsigned loci;
        int unsigned l;
        int unsigned j;
        int unsigned random_base;
        int unsigned set_base;
        bit quiet;

        // Missing alleles, extreme codes and populations, then several short data sets.
        push_request(16'd0, 16'd0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        push_request(16'd5, 16'd0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        push_request(16'd0, 16'd5, 6'd63, 1'b0, 1'b0, 1'b0, 1'b0);
        push_request(16'hFFFF, 16'hFFFF, 6'd63, 1'b0, 1'b0, 1'b0, 1'b0);
        push_request(16'd1, 16'hFFFF, 6'd63, 1'b0, 1'b0, 1'b0, 1'b0);
        push_request(16'd5, 16'd5, 6'd0, 1'b1, 1'b0, 1'b0, 1'b0);
        push_request(16'd7, 16'd7, 6'd21, 1'b0, 1'b0, 1'b0, 1'b0);
        push_request(16'd7, 16'd8, 6'd21, 1'b0, 1'b0, 1'b0, 1'b0);
        push_request(16'd8, 16'd7, 6'd42, 1'b0, 1'b0, 1'b0, 1'b0);
        push_request(16'd7, 16'd0, 6'd42, 1'b0, 1'b1, 1'b0, 1'b0);
        push_request(16'd3, 16'd3, 6'd5, 1'b0, 1'b1, 1'b0, 1'b0);
        push_request(16'd1, 16'd2, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0);
        push_request(16'd2, 16'd1, 6'd0, 1'b1, 1'b1, 1'b0, 1'b0);
        push_request(16'd9, 16'd9, 6'd3, 1'b0, 1'b0, 1'b0, 1'b0);
        push_request(16'd9, 16'd9, 6'd3, 1'b0, 1'b1, 1'b0, 1'b0);

        random_base = requests_total;
        set_base = sets_queued;
        quiet = 1'b0;
        while (requests_total - random_base < RANDOM_ITEMS ||
               sets_queued - set_base < MIN_SETS) begin
            if (requests_total - random_base >= CALM_AFTER) begin
                quiet = 1'b1;
            end
            if ($urandom_range(0, 9) == 0) begin
                push_request(pick_allele(), pick_allele(), pick_pop(), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 3) == 0), requests_total == random_base, quiet);
            end else begin
                loci = $urandom_range(1, 4);
                for (l = 0; l < loci; l++) begin
                    len = $urandom_range(1, 8);
                    for (j = 0; j < len; j++) begin
                        push_request(pick_allele(), pick_allele(), pick_pop(), j == len - 1,
                                     (j == len - 1) && (l == loci - 1),
                                     requests_total == random_base, quiet);
                    end
                end
            end
        end
        if (!pending_q[pending_q.size() - 1].data_end) begin
            push_request(pick_allele(), pick_allele(), pick_pop(), 1'b1, 1'b1, 1'b0, 1'b1);
        end

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        while ((requests_taken < requests_total || expected_q.size() != 0) &&
               cycle_count < CYCLE_LIMIT) begin
            @(negedge aclk);
        end

        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_allele_identity_pair_counter_top failed");
        end else begin
            repeat (SETTLE) @(negedge aclk);
            $display("Sent %0d genotype requests over %0d data sets.",
                     requests_taken, sets_queued);
            $display("Checked %0d count results with %0d mismatches.", results_seen, errors);
            if (errors == 0 && expected_q.size() == 0) begin
                $display("tb_allele_identity_pair_counter_top passed");
            end else begin
                $display("tb_allele_identity_pair_counter_top failed");
            end
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/aipc_pkg.sv
src/aipc_store.sv
src/aipc_counters.sv
src/allele_identity_pair_counter_top.sv
test/tb_allele_identity_pair_counter_top.sv
